[rtl/blpw_pkg.sv]
// ----------------------------------------------------------------------------
// blpw_pkg
// Shared types and fixed constants of the Bresenham line plane writer.
// ----------------------------------------------------------------------------
`default_nettype none

package blpw_pkg;

  // Raster geometry: two planes of SplitRow rows, BytesPerRow bytes per row
  localparam int unsigned SplitRow    = 200;
  localparam int unsigned BytesPerRow = 80;

  // Field widths
  localparam int unsigned XW     = 10;
  localparam int unsigned YW     = 9;
  localparam int unsigned ColW   = 7;
  localparam int unsigned OffW   = 14;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned ErrW   = 11;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // Leftmost pixel of a byte
  localparam logic [MaskW-1:0] MaskLeft = 8'h80;

  // Request kind carried on the slave tuser
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

endpackage : blpw_pkg

`default_nettype wire

[rtl/blpw_pixel_addr.sv]
// ----------------------------------------------------------------------------
// blpw_pixel_addr
// Maps a raster row and byte column to a plane and a byte offset in it.
// ----------------------------------------------------------------------------
`default_nettype none

module blpw_pixel_addr (
  input  logic [blpw_pkg::YW-1:0]   row_i,
  input  logic [blpw_pkg::ColW-1:0] byte_col_i,
  output logic                      plane_o,
  output logic [blpw_pkg::OffW-1:0] offset_o
);
  import blpw_pkg::*;

  logic [YW-1:0] row_in_half;
  logic [15:0]   offset_full;

  assign plane_o     = (row_i >= YW'(SplitRow));
  assign row_in_half = plane_o ? (row_i - YW'(SplitRow)) : row_i;
  // row times bytes per row, then the column; keep the low offset bits
  assign offset_full = (16'(row_in_half) * 16'(BytesPerRow)) + 16'(byte_col_i);
  assign offset_o    = offset_full[OffW-1:0];

endmodule : blpw_pixel_addr

`default_nettype wire

[rtl/bresenham_line_plane_writer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_plane_writer
// Bresenham line walker emitting one-bit pixel writes into a two-plane raster.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*): one request per accepted beat. tuser selects
//   the kind: start (load endpoints, no result) or step (emit one pixel).
//   Master channel (m_axis_*): one pixel write per step taken while a line
//   is running; tuser is the plane, tlast marks the final pixel of the line.
//   Steps while no line is running are dropped without a result.
//   A start while a line runs abandons it and loads the new line.
// Pipeline and throughput:
//   A request goes into an input register, is worked by the walker logic
//   when it leaves that register, and its result lands in the output
//   register; a stall on the output can hold it in the input register.
//   One request per cycle is taken while the receiver keeps up; the walker
//   update (one add, one compare, one constant multiply for the address)
//   sets that figure.
// Reset:
//   rst_ni clears both registers' valid flags and the walker state; no line
//   is running afterwards.
// Stall:
//   When the receiver holds m_axis_tready low, the output register holds its
//   pixel, the input register holds one more request, and s_axis_tready
//   drops until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_plane_writer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request channel
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [9:0] x_start, [18:10] y_start, [28:19] x_end, [37:29] y_end, [39:38] zero
  input  logic [blpw_pkg::InDataW-1:0]       s_axis_tdata_i,
  // [0] op
  input  logic                               s_axis_tuser_i,
  // Pixel write channel
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [13:0] byte_offset, [21:14] bit_mask, [23:22] zero
  output logic [blpw_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // [0] plane_sel
  output logic                               m_axis_tuser_o,
  // last_pixel
  output logic                               m_axis_tlast_o
);
  import blpw_pkg::*;

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic          in_vld_q;
  op_e           in_op_q;
  logic [XW-1:0] in_xs_q, in_xe_q;
  logic [YW-1:0] in_ys_q, in_ye_q;

  logic out_free;
  logic in_fire;    // request leaves the input register this cycle
  logic s_fire;

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign in_fire         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q <= op_e'(s_axis_tuser_i);
      in_xs_q <= s_axis_tdata_i[9:0];
      in_ys_q <= s_axis_tdata_i[18:10];
      in_xe_q <= s_axis_tdata_i[28:19];
      in_ye_q <= s_axis_tdata_i[37:29];
    end
  end

  // --------------------------------------------------------------------------
  // Walker state
  // --------------------------------------------------------------------------
  logic             active_q, active_d;
  logic             x_major_q, x_major_d;
  logic             going_up_q, going_up_d;
  logic [XW-1:0]    delta_x_q, delta_x_d;
  logic [YW-1:0]    delta_y_q, delta_y_d;
  logic [XW-1:0]    remaining_q, remaining_d;
  logic [ErrW-1:0]  err_q, err_d;
  logic [YW-1:0]    row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [MaskW-1:0] mask_q, mask_d;

  // Start decode: order the endpoints so that x rises
  logic          swap;
  logic [XW-1:0] sx0, sx1, sdx;
  logic [YW-1:0] sy0, sy1, sdy;
  logic          s_up, s_xmaj;
  logic [XW-1:0] s_major;

  assign swap   = in_xs_q > in_xe_q;
  assign sx0    = swap ? in_xe_q : in_xs_q;
  assign sx1    = swap ? in_xs_q : in_xe_q;
  assign sy0    = swap ? in_ye_q : in_ys_q;
  assign sy1    = swap ? in_ys_q : in_ye_q;
  assign sdx    = sx1 - sx0;
  assign s_up   = sy0 > sy1;
  assign sdy    = s_up ? (sy0 - sy1) : (sy1 - sy0);
  assign s_xmaj = sdx > XW'(sdy);
  assign s_major = s_xmaj ? sdx : XW'(sdy);

  // Step: one Bresenham update
  logic             is_start, is_step, emit, last;
  logic [ErrW:0]    minor_ext, major_ext;
  logic [ErrW:0]    err_sub, err_fix;
  logic             carry;       // error went negative: move on the minor axis
  logic             mv_x, mv_y;
  logic [MaskW-1:0] mask_adv;
  logic [ColW-1:0]  col_adv;
  logic [YW-1:0]    row_adv;

  assign is_start  = in_fire && (in_op_q == OP_START);
  assign is_step   = in_fire && (in_op_q == OP_STEP);
  assign emit      = is_step && active_q;
  assign last      = (remaining_q == '0);

  assign minor_ext = x_major_q ? (ErrW+1)'(delta_y_q) : (ErrW+1)'(delta_x_q);
  assign major_ext = x_major_q ? (ErrW+1)'(delta_x_q) : (ErrW+1)'(delta_y_q);
  assign err_sub   = {err_q[ErrW-1], err_q} - minor_ext;
  assign carry     = err_sub[ErrW];
  assign err_fix   = carry ? (err_sub + major_ext) : err_sub;
  assign mv_x      = x_major_q || carry;
  assign mv_y      = !x_major_q || carry;

  assign mask_adv  = (mask_q == MaskW'(1)) ? MaskLeft : (mask_q >> 1);
  assign col_adv   = (mask_q == MaskW'(1)) ? (col_q + ColW'(1)) : col_q;
  assign row_adv   = going_up_q ? (row_q - YW'(1)) : (row_q + YW'(1));

  always_comb begin
    active_d    = active_q;
    x_major_d   = x_major_q;
    going_up_d  = going_up_q;
    delta_x_d   = delta_x_q;
    delta_y_d   = delta_y_q;
    remaining_d = remaining_q;
    err_d       = err_q;
    row_d       = row_q;
    col_d       = col_q;
    mask_d      = mask_q;
    if (is_start) begin
      active_d    = 1'b1;
      x_major_d   = s_xmaj;
      going_up_d  = s_up;
      delta_x_d   = sdx;
      delta_y_d   = sdy;
      remaining_d = s_major;
      err_d       = ErrW'(s_major >> 1);
      row_d       = sy0;
      col_d       = sx0[XW-1:3];
      mask_d      = MaskLeft >> sx0[2:0];
    end else if (emit) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        remaining_d = remaining_q - XW'(1);
        err_d       = err_fix[ErrW-1:0];
        if (mv_x) begin
          mask_d = mask_adv;
          col_d  = col_adv;
        end
        if (mv_y) begin
          row_d = row_adv;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      x_major_q   <= 1'b0;
      going_up_q  <= 1'b0;
      delta_x_q   <= '0;
      delta_y_q   <= '0;
      remaining_q <= '0;
      err_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      mask_q      <= MaskLeft;
    end else begin
      active_q    <= active_d;
      x_major_q   <= x_major_d;
      going_up_q  <= going_up_d;
      delta_x_q   <= delta_x_d;
      delta_y_q   <= delta_y_d;
      remaining_q <= remaining_d;
      err_q       <= err_d;
      row_q       <= row_d;
      col_q       <= col_d;
      mask_q      <= mask_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel address of the current position
  // --------------------------------------------------------------------------
  logic            cur_plane;
  logic [OffW-1:0] cur_offset;

  blpw_pixel_addr u_addr (
    .row_i      (row_q),
    .byte_col_i (col_q),
    .plane_o    (cur_plane),
    .offset_o   (cur_offset)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic             out_vld_q;
  logic             out_plane_q;
  logic [OffW-1:0]  out_offset_q;
  logic [MaskW-1:0] out_mask_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_plane_q  <= cur_plane;
      out_offset_q <= cur_offset;
      out_mask_q   <= mask_q;
      out_last_q   <= last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_mask_q, out_offset_q};
  assign m_axis_tuser_o  = out_plane_q;
  assign m_axis_tlast_o  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // The pixel mask register always holds exactly one set bit
  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mask_q))
    else $error("walker mask is not one-hot");

  // A request that leaves the input register without a pixel leaves no result
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !emit) |=> !out_vld_q)
    else $error("result appeared for a request that gives none");

  // The final pixel of a line ends the line
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (!active_q && out_vld_q && out_last_q))
    else $error("line still running after its last pixel");

  // A pending request holds while the output register is blocked
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> (in_vld_q && $stable(in_op_q) && $stable(in_xs_q)))
    else $error("input register changed while stalled");

  // A start never produces a result
  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> (!out_vld_q && active_q))
    else $error("start request produced a result or did not load a line");
`endif

endmodule : bresenham_line_plane_writer

`default_nettype wire
